// ===== sv/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants, event codes and the command word passed front to back
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FRAME_LEN    = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int FLAG_BYTE    = 23;
  localparam int CH_BITS      = 11;
  localparam int DATA_BITS    = NUM_CHANNELS * CH_BITS;
  localparam int DATA_BYTES   = DATA_BITS / 8;
  localparam int FILL_W       = 5;
  localparam int CH_IDX_W     = 4;
  localparam int GAP_W        = 20;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 32;

  localparam logic [7:0]       HEADER_BYTE = 8'h0F;
  localparam logic [3:0]       FOOTER_OK_A = 4'h0;
  localparam logic [3:0]       FOOTER_OK_B = 4'h4;
  localparam logic [GAP_W-1:0] GAP_RESET   = 20'd2000;

  localparam logic [1:0] EV_BUFFERED = 2'd0;
  localparam logic [1:0] EV_DROPPED  = 2'd1;
  localparam logic [1:0] EV_BAD_FOOT = 2'd2;
  localparam logic [1:0] EV_CHANNEL  = 2'd3;

  typedef struct packed {
    logic [1:0]           event_res;
    logic [3:0]           flags;
    logic [CNT_W-1:0]     resync_total;
    logic [CNT_W-1:0]     bad_footer_total;
    logic [CNT_W-1:0]     frame_total;
    logic [DATA_BITS-1:0] chan_data;
  } sfd_cmd_t;

endpackage
`default_nettype wire

// ===== sv/sfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_byte_if / sfd_result_if
// valid/ready channels for received bytes and decoded results
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output data_byte, output time_us, input ready);
  modport sink   (input valid, input data_byte, input time_us, output ready);
endinterface

interface sfd_result_if;
  import sfd_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          event_res;
  logic [CH_IDX_W-1:0] channel_index;
  logic [CH_BITS-1:0]  channel_value;
  logic                digital_ch17;
  logic                digital_ch18;
  logic                lost_frame;
  logic                fail_safe;
  logic                last;
  logic [CNT_W-1:0]    resync_total;
  logic [CNT_W-1:0]    bad_footer_total;
  logic [CNT_W-1:0]    frame_total;

  modport source (output valid, output event_res, output channel_index,
                  output channel_value, output digital_ch17, output digital_ch18,
                  output lost_frame, output fail_safe, output last,
                  output resync_total, output bad_footer_total, output frame_total,
                  input ready);
  modport sink   (input valid, input event_res, input channel_index,
                  input channel_value, input digital_ch17, input digital_ch18,
                  input lost_frame, input fail_safe, input last,
                  input resync_total, input bad_footer_total, input frame_total,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/sfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_front
// gap check, frame assembly, footer check and counters; one command per byte
// ----------------------------------------------------------------------------
module sfd_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [sfd_pkg::GAP_W-1:0] cfg_wr_data,
  sfd_byte_if.sink                      rx,
  output logic                          cmd_valid,
  output sfd_pkg::sfd_cmd_t             cmd,
  input  wire logic                     cmd_ready
);
  import sfd_pkg::*;

  logic [GAP_W-1:0]  gap_us;
  logic              seen_time;
  logic [TIME_W-1:0] prev_time;
  logic [FILL_W-1:0] fill_count;
  logic [CNT_W-1:0]  resync_counter;
  logic [CNT_W-1:0]  footer_counter;
  logic [CNT_W-1:0]  good_counter;
  logic [7:0]        frame_store [1:FLAG_BYTE];

  logic              accept;
  logic [TIME_W-1:0] elapsed;
  logic              gap_hit;
  logic [FILL_W-1:0] fill_eff;
  logic [1:0]        resync_inc;
  logic              footer_inc;
  logic              good_inc;
  logic              store_wr;
  logic [FILL_W-1:0] fill_count_next;
  logic [1:0]        ev;
  logic [DATA_BITS-1:0] frame_bits;

  assign accept    = rx.valid && cmd_ready;
  assign rx.ready  = cmd_ready;
  assign cmd_valid = accept;

  always_comb begin
    elapsed  = rx.time_us - prev_time;
    gap_hit  = seen_time && (elapsed >= {{(TIME_W-GAP_W){1'b0}}, gap_us});
    fill_eff = gap_hit ? '0 : fill_count;
    resync_inc      = {1'b0, gap_hit && (fill_count != '0)};
    footer_inc      = 1'b0;
    good_inc        = 1'b0;
    store_wr        = 1'b0;
    fill_count_next = '0;
    if (fill_eff == '0 && rx.data_byte != HEADER_BYTE) begin
      ev         = EV_DROPPED;
      resync_inc = resync_inc + 2'd1;
    end else if (fill_eff < FILL_W'(FRAME_LEN - 1)) begin
      ev              = EV_BUFFERED;
      store_wr        = 1'b1;
      fill_count_next = fill_eff + FILL_W'(1);
    end else if (rx.data_byte[3:0] != FOOTER_OK_A && rx.data_byte[3:0] != FOOTER_OK_B) begin
      ev         = EV_BAD_FOOT;
      footer_inc = 1'b1;
    end else begin
      ev       = EV_CHANNEL;
      good_inc = 1'b1;
    end
  end

  // channel bits, byte 1 in the low end
  always_comb begin
    for (int i = 1; i <= DATA_BYTES; i++) begin
      frame_bits[8*(i-1) +: 8] = frame_store[i];
    end
  end

  always_comb begin
    cmd.event_res        = ev;
    cmd.resync_total     = resync_counter + {{(CNT_W-2){1'b0}}, resync_inc};
    cmd.bad_footer_total = footer_counter + {{(CNT_W-1){1'b0}}, footer_inc};
    cmd.frame_total      = good_counter + {{(CNT_W-1){1'b0}}, good_inc};
    cmd.flags            = good_inc ? frame_store[FLAG_BYTE][3:0] : 4'd0;
    cmd.chan_data        = good_inc ? frame_bits : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_us         <= GAP_RESET;
      seen_time      <= 1'b0;
      prev_time      <= '0;
      fill_count     <= '0;
      resync_counter <= '0;
      footer_counter <= '0;
      good_counter   <= '0;
    end else begin
      if (cfg_wr_en) begin
        gap_us <= cfg_wr_data;
      end
      if (accept) begin
        seen_time      <= 1'b1;
        prev_time      <= rx.time_us;
        fill_count     <= fill_count_next;
        resync_counter <= cmd.resync_total;
        footer_counter <= cmd.bad_footer_total;
        good_counter   <= cmd.frame_total;
      end
    end
  end

  // header byte itself needs no storage
  always_ff @(posedge clk) begin
    for (int i = 1; i <= FLAG_BYTE; i++) begin
      if (accept && store_wr && fill_eff == FILL_W'(i)) begin
        frame_store[i] <= rx.data_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_queue
// two-entry command fifo between front and back
// ----------------------------------------------------------------------------
module sfd_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  input  sfd_pkg::sfd_cmd_t wr_cmd,
  output logic              wr_ready,
  output logic              rd_valid,
  output sfd_pkg::sfd_cmd_t rd_cmd,
  input  wire logic         rd_ready
);
  import sfd_pkg::*;

  sfd_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_back
// turns commands into result words; a good frame is walked, while res is ready, one channel a cycle
// ----------------------------------------------------------------------------
module sfd_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  sfd_pkg::sfd_cmd_t cmd,
  output logic              cmd_ready,
  sfd_result_if.source      res
);
  import sfd_pkg::*;

  logic                 out_valid;
  logic [1:0]           ev;
  logic [3:0]           flags;
  logic [CNT_W-1:0]     resync_total;
  logic [CNT_W-1:0]     bad_footer_total;
  logic [CNT_W-1:0]     frame_total;
  logic [DATA_BITS-1:0] shift_data;
  logic [CH_IDX_W-1:0]  ch;
  logic                 is_last;
  logic                 fire;

  assign is_last   = (ev != EV_CHANNEL) || (ch == CH_IDX_W'(NUM_CHANNELS - 1));
  assign fire      = out_valid && res.ready;
  assign cmd_ready = !out_valid || (fire && is_last);

  assign res.valid            = out_valid;
  assign res.event_res        = ev;
  assign res.channel_index    = ch;
  assign res.channel_value    = shift_data[CH_BITS-1:0];
  assign res.digital_ch17     = flags[0];
  assign res.digital_ch18     = flags[1];
  assign res.lost_frame       = flags[2];
  assign res.fail_safe        = flags[3];
  assign res.last             = is_last;
  assign res.resync_total     = resync_total;
  assign res.bad_footer_total = bad_footer_total;
  assign res.frame_total      = frame_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready) begin
      ev               <= cmd.event_res;
      flags            <= cmd.flags;
      resync_total     <= cmd.resync_total;
      bad_footer_total <= cmd.bad_footer_total;
      frame_total      <= cmd.frame_total;
      shift_data       <= cmd.chan_data;
      ch               <= '0;
    end else if (fire) begin
      shift_data <= shift_data >> CH_BITS;
      ch         <= ch + CH_IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== sv/sbus_frame_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// serial frame decoder: timestamped bytes in, status and channel words out
// ----------------------------------------------------------------------------
// usage
//   rx carries one received byte and its microsecond arrival stamp per word.
//   res carries result words; every byte gives one status word, except the
//   byte that closes a good frame, which gives sixteen channel words.
//   res.last marks the final word caused by a byte.
//   cfg_wr_en/cfg_wr_data write the inter-byte gap register (reset 2000 us).
// timing
//   the front takes a byte every cycle while the two-entry command queue has
//   room; with the back idle, the first result word of a byte passes through
//   the queue entry and then the back's output register before it is on res.
//   the back emits one word a cycle while res is ready, so a good frame holds
//   it for sixteen words and any other byte for one; that channel walk sets the rate.
// reset and stall
//   rst (synchronous) clears the counters, the frame fill and the gap
//   history and restores the gap register; the frame store is not cleared.
//   a stalled res holds the current word; the queue then fills and rx.ready
//   drops until the back frees an entry.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sfd_pkg::GAP_W-1:0] cfg_wr_data,
  sfd_byte_if.sink                       rx,
  sfd_result_if.source                   res
);
  import sfd_pkg::*;

  // front to queue
  logic     f_valid;
  logic     f_ready;
  sfd_cmd_t f_cmd;

  // queue to back
  logic     b_valid;
  logic     b_ready;
  sfd_cmd_t b_cmd;

  // classify each byte, keep counters and the partial frame
  sfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx),
    .cmd_valid   (f_valid),
    .cmd         (f_cmd),
    .cmd_ready   (f_ready)
  );

  // lets the front keep taking bytes while a frame is being emitted
  sfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_cmd   (f_cmd),
    .wr_ready (f_ready),
    .rd_valid (b_valid),
    .rd_cmd   (b_cmd),
    .rd_ready (b_ready)
  );

  // output register and channel walk
  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_ready (b_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// timestamped serial bytes go through sbus_frame_decoder_core under several
// gap settings and idle patterns; a mirror of the decoder predicts every
// result word, and each received word is checked in order
// ----------------------------------------------------------------------------
module testbench;
  import sfd_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  // one decoded result word as the checker sees it
  typedef struct packed {
    logic [1:0]          event_res;
    logic [CH_IDX_W-1:0] chan;
    logic [CH_BITS-1:0]  value;
    logic [3:0]          flags;
    logic                is_last;
    logic [CNT_W-1:0]    resyncs;
    logic [CNT_W-1:0]    bad_footers;
    logic [CNT_W-1:0]    frames;
  } res_word_t;

  // one received byte waiting to be sent
  typedef struct {
    logic [7:0]        data;
    logic [TIME_W-1:0] stamp;
    bit                drain_first;
  } rx_item_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [GAP_W-1:0] cfg_wr_data;

  sfd_byte_if   rx_bus ();
  sfd_result_if res_bus ();

  sbus_frame_decoder_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_bus),
    .res         (res_bus)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes still to send and words still to arrive
  rx_item_t  byte_queue[$];
  res_word_t pending_words[$];
  logic      drained;
  int        tx_idle_pct;
  int        rx_stall_pct;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // decoder mirror: gap register, timing history, frame fill and counters
  logic [GAP_W-1:0]  gap_model;
  logic              seen_stamp;
  logic [TIME_W-1:0] prev_stamp;
  logic [FILL_W-1:0] fill_level;
  logic [7:0]        frame_bytes [FRAME_LEN];
  logic [CNT_W-1:0]  resync_cnt;
  logic [CNT_W-1:0]  bad_footer_cnt;
  logic [CNT_W-1:0]  frame_cnt;

  // running timestamp of the byte generator
  logic [TIME_W-1:0] clock_us;

  // queue one expected word carrying the counters as they stand now
  function automatic void push_word(logic [1:0] ev, logic [CH_IDX_W-1:0] ch,
                                    logic [CH_BITS-1:0] val, logic [3:0] fl,
                                    logic lst);
    pending_words.push_back('{event_res: ev, chan: ch, value: val, flags: fl,
                              is_last: lst, resyncs: resync_cnt,
                              bad_footers: bad_footer_cnt, frames: frame_cnt});
  endfunction

  // advance the mirror by one accepted byte and queue the words it causes
  function automatic void decode_byte(logic [7:0] b, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    logic [23:0]       win;
    logic [3:0]        footer;
    int                bitpos;
    int                at;
    // silence since the last byte, modulo 2^32; no check before the first byte
    elapsed = now - prev_stamp;
    if (seen_stamp && elapsed >= TIME_W'(gap_model)) begin
      if (fill_level != 0) resync_cnt++;
      fill_level = 0;
    end
    seen_stamp = 1'b1;
    prev_stamp = now;
    // waiting for a header: anything else is dropped
    if (fill_level == 0 && b != HEADER_BYTE) begin
      resync_cnt++;
      push_word(EV_DROPPED, '0, '0, '0, 1'b1);
      return;
    end
    // a header met mid-frame lands here as plain data
    frame_bytes[fill_level] = b;
    fill_level++;
    if (fill_level < FRAME_LEN) begin
      push_word(EV_BUFFERED, '0, '0, '0, 1'b1);
      return;
    end
    fill_level = 0;
    footer = frame_bytes[FRAME_LEN-1][3:0];
    if (footer != FOOTER_OK_A && footer != FOOTER_OK_B) begin
      bad_footer_cnt++;
      push_word(EV_BAD_FOOT, '0, '0, '0, 1'b1);
      return;
    end
    frame_cnt++;
    // channels are packed lsb-first starting at byte 1
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      bitpos = ch * CH_BITS;
      at     = 1 + bitpos / 8;
      win    = {frame_bytes[at+2], frame_bytes[at+1], frame_bytes[at]};
      push_word(EV_CHANNEL, CH_IDX_W'(ch), CH_BITS'(win >> (bitpos % 8)),
                frame_bytes[FLAG_BYTE][3:0], ch == NUM_CHANNELS - 1);
    end
  endfunction

  function automatic void report_word(string what, res_word_t want, res_word_t got);
    if (mismatch_count < MAX_REPORTS)
      $display({"%s: expected ev=%0d ch=%0d val=%0d fl=%h last=%0d rs=%0d bf=%0d",
                " fr=%0d, got ev=%0d ch=%0d val=%0d fl=%h last=%0d rs=%0d bf=%0d",
                " fr=%0d"},
               what, want.event_res, want.chan, want.value, want.flags, want.is_last,
               want.resyncs, want.bad_footers, want.frames,
               got.event_res, got.chan, got.value, got.flags, got.is_last,
               got.resyncs, got.bad_footers, got.frames);
    mismatch_count++;
  endfunction

  // driver: offer the head of the byte queue, hold a word until taken
  always @(posedge clk) begin
    if (rst) begin
      rx_bus.valid <= 1'b0;
    end else begin
      bit accepted;
      accepted = rx_bus.valid && rx_bus.ready;
      if (accepted) void'(byte_queue.pop_front());
      if (rx_bus.valid && !accepted) begin
        // word still on the bus, keep it steady
      end else if (byte_queue.size() != 0 &&
                   (!byte_queue[0].drain_first || (drained && !accepted)) &&
                   $urandom_range(99, 0) >= tx_idle_pct) begin
        rx_bus.valid     <= 1'b1;
        rx_bus.data_byte <= byte_queue[0].data;
        rx_bus.time_us   <= byte_queue[0].stamp;
      end else begin
        rx_bus.valid <= 1'b0;
      end
    end
  end

  // monitor: check each result word, then predict from each accepted byte
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      drained       <= 1'b1;
    end else begin
      res_word_t got;
      res_word_t want;
      if (res_bus.valid && res_bus.ready) begin
        got = '{event_res: res_bus.event_res, chan: res_bus.channel_index,
                value: res_bus.channel_value,
                flags: {res_bus.fail_safe, res_bus.lost_frame,
                        res_bus.digital_ch18, res_bus.digital_ch17},
                is_last: res_bus.last, resyncs: res_bus.resync_total,
                bad_footers: res_bus.bad_footer_total, frames: res_bus.frame_total};
        if (pending_words.size() == 0) begin
          report_word("unexpected word", '0, got);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) report_word("mismatch", want, got);
        end
      end
      // a result for a byte taken at this edge cannot be on the bus yet
      if (rx_bus.valid && rx_bus.ready) decode_byte(rx_bus.data_byte, rx_bus.time_us);
      drained       <= (pending_words.size() == 0);
      res_bus.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // gap register write, only while the block is idle
  task automatic write_gap(logic [GAP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    gap_model    = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // wait until every byte is sent and every word has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_queue.size() != 0 || rx_bus.valid || !drained);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_byte(logic [7:0] b, logic [TIME_W-1:0] delta, bit hold);
    clock_us += delta;
    byte_queue.push_back('{data: b, stamp: clock_us, drain_first: hold});
  endtask

  // spacing inside a frame: below the gap, or 0 to 3 when the gap is zero
  function automatic logic [TIME_W-1:0] inner_delta();
    if (gap_model == 0) return TIME_W'($urandom_range(3, 0));
    return TIME_W'($urandom_range(gap_model - 1, 0));
  endfunction

  // spacing that marks a frame boundary: at or above the gap
  function automatic logic [TIME_W-1:0] boundary_delta();
    if ($urandom_range(1, 0)) return TIME_W'(gap_model) + $urandom_range(50, 0);
    return $urandom_range(32'hFFFF_FFFF, TIME_W'(gap_model));
  endfunction

  // header plus n_bytes-1 bytes; a full-length frame ends in a footer
  task automatic add_frame(int n_bytes, bit good_footer, bit fresh, bit hold);
    logic [7:0] b;
    logic [3:0] nib;
    add_byte(HEADER_BYTE, fresh ? boundary_delta() : inner_delta(), hold);
    for (int i = 1; i < n_bytes; i++) begin
      if (i == FRAME_LEN - 1) begin
        if (good_footer) begin
          nib = $urandom_range(1, 0) ? FOOTER_OK_B : FOOTER_OK_A;
        end else begin
          do nib = 4'($urandom);
          while (nib == FOOTER_OK_A || nib == FOOTER_OK_B);
        end
        b = {4'($urandom), nib};
      end else begin
        // now and then a header value as plain data
        b = ($urandom_range(7, 0) == 0) ? HEADER_BYTE : 8'($urandom);
      end
      add_byte(b, inner_delta(), 1'b0);
    end
  endtask

  // mostly well-formed frames, with bad footers, cut frames and noise mixed in
  task automatic run_random(int n_items, bit with_drain);
    bit complete;
    bit hold;
    int pick;
    complete = 1'b0;
    while (byte_queue.size() < n_items) begin
      pick = $urandom_range(9, 0);
      hold = with_drain && byte_queue.size() >= n_items / 2;
      if (hold) with_drain = 1'b0;
      if (pick <= 5) begin
        add_frame(FRAME_LEN, 1'b1, !complete || $urandom_range(1, 0), hold);
        complete = 1'b1;
      end else if (pick == 6) begin
        add_frame(FRAME_LEN, 1'b0, !complete || $urandom_range(1, 0), hold);
        complete = 1'b1;
      end else if (pick == 7) begin
        add_frame($urandom_range(FRAME_LEN - 1, 2), 1'b1, 1'b1, hold);
        complete = 1'b0;
      end else begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom), $urandom, hold);
        complete = 1'b0;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    rx_bus.valid     = 1'b0;
    rx_bus.data_byte = '0;
    rx_bus.time_us   = '0;
    res_bus.ready    = 1'b0;
    drained          = 1'b1;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    clock_us         = '0;
    // mirror starts in the reset state
    gap_model        = GAP_RESET;
    seen_stamp       = 1'b0;
    prev_stamp       = '0;
    fill_level       = '0;
    resync_cnt       = '0;
    bad_footer_cnt   = '0;
    frame_cnt        = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: first byte with no gap check, a wrapped stamp, then one
    // good frame with all-ones and all-zero channels and a header as data
    write_gap(GAP_RESET);
    add_byte(8'h00, 32'd0, 1'b0);
    add_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_byte(HEADER_BYTE, 32'd5, 1'b0);
    for (int i = 1; i < FRAME_LEN - 1; i++)
      add_byte((i <= 11 || i == FLAG_BYTE) ? 8'hFF : (i == 12 ? HEADER_BYTE : 8'h00),
               32'd1, 1'b0);
    add_byte({4'h0, FOOTER_OK_B}, 32'd1, 1'b0);
    wait_idle();

    // moderate gap, no idling
    write_gap(GAP_W'($urandom_range(5000, 50)));
    run_random(45, 1'b0);
    wait_idle();

    // largest gap, sender idling, stamps crossing the 32-bit wrap
    write_gap('1);
    tx_idle_pct = 61;
    clock_us    = 32'hFFFF_0000;
    run_random(45, 1'b1);
    wait_idle();

    // smallest nonzero gap, receiver stalling
    write_gap(GAP_W'(1));
    tx_idle_pct  = 0;
    rx_stall_pct = 61;
    run_random(45, 1'b0);
    wait_idle();

    // zero gap: every byte is a boundary
    write_gap('0);
    tx_idle_pct  = 37;
    rx_stall_pct = 37;
    for (int i = 0; i < 16; i++)
      add_byte(i % 2 == 0 ? HEADER_BYTE : 8'($urandom), $urandom_range(3, 0), 1'b0);
    wait_idle();

    // random gap, both sides idling
    write_gap(GAP_W'($urandom));
    run_random(50, 1'b1);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sbus_frame_decoder_core.f =====
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_front.sv
sv/sfd_queue.sv
sv/sfd_back.sv
sv/sbus_frame_decoder_core.sv
verif/testbench.sv
